@@ hdl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared widths, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int WORD_W     = 64;   // map bits per memory word
    localparam int WORD_IDX_W = 6;    // bit index within a word
    localparam int FRAME_W    = 20;
    localparam int KF_W       = 13;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [FRAME_W-1:0] FRAME_BASE_RST = 20'd524800;   // 0x80200000 / 4096

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_FRAMES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE    = 1'b1;

    typedef struct packed {
        logic                  found;
        logic [WORD_IDX_W-1:0] index;
    } hit_t;

endpackage

@@ hdl/bfa_find_zero.sv @@
// ----------------------------------------------------------------------------
// bfa_find_zero
// Priority encoder: lowest clear bit of one map word.
// ----------------------------------------------------------------------------
module bfa_find_zero
    import bfa_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output hit_t              hit
);

    always_comb
    begin
        hit.found = 1'b0;
        hit.index = '0;
        // walk downwards so the lowest clear bit wins
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (!word[j])
            begin
                hit.found = 1'b1;
                hit.index = WORD_IDX_W'(j);
            end
        end
    end

endmodule

@@ hdl/bitmap_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame used map held in
// a synchronous memory of 64-bit words.
// ----------------------------------------------------------------------------
// Sequence from the start transfer to the done strobe: free and query decode,
// read the map word, then write back or return the bit; a frame outside the
// map ends at decode, as does the unused code. Allocate writes the kernel
// reservation words on the first allocate, then scans the map words (one per
// cycle through the memory read port, up to ceil(NUM_FRAMES/64)).
// One item at a time; busy is high until the strobe cycle. Results cannot be
// stalled. After reset a clearing pass over all ceil(NUM_FRAMES/64) words (64 by
// default) zeroes the map while busy is high; config writes are taken anyway.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_FRAMES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [FRAME_W-1:0]   wr_data,

    // command
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [FRAME_W-1:0]   frame,

    // result
    output logic                 done,
    output logic [FRAME_W-1:0]   frame_out,
    output logic [STATUS_W-1:0]  status,
    output logic                 is_used
);

    // map geometry
    localparam int DEPTH     = (NUM_FRAMES + WORD_W - 1) / WORD_W;
    localparam int ROW_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAST_BITS = NUM_FRAMES - (DEPTH - 1) * WORD_W;

    localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(DEPTH - 1);
    localparam logic [FRAME_W-1:0] NUM_F    = FRAME_W'(NUM_FRAMES);
    // bits of the last word that lie beyond the map read as used
    localparam logic [WORD_W-1:0]  TAIL_MASK =
        ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    // sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;   // clearing pass after reset
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DISP = 3'd2;   // decode the command
    localparam logic [2:0] ST_RSV  = 3'd3;   // kernel reservation writes
    localparam logic [2:0] ST_SCAN = 3'd4;   // issue first scan read
    localparam logic [2:0] ST_SCHK = 3'd5;   // check a word, read the next
    localparam logic [2:0] ST_FREE = 3'd6;   // write back the cleared bit
    localparam logic [2:0] ST_QRY  = 3'd7;   // return the read bit

    // the map memory
    logic [WORD_W-1:0] map_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ROW_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ROW_W-1:0]  mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    // control and payload registers
    logic [2:0]          state_reg,     state_next;
    logic [ROW_W-1:0]    cnt_reg,       cnt_next;
    logic [ROW_W-1:0]    row_reg,       row_next;
    logic                first_reg,     first_next;
    logic                reserved_reg,  reserved_next;
    logic [FRAME_W-1:0]  pos_reg,       pos_next;
    logic [OP_W-1:0]     op_reg,        op_next;
    logic [FRAME_W-1:0]  frame_reg,     frame_next;
    logic                done_reg,      done_next;
    logic [FRAME_W-1:0]  frame_out_reg, frame_out_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic                is_used_reg,   is_used_next;
    logic [KF_W-1:0]     kf_reg;
    logic [FRAME_W-1:0]  base_reg;

    // scan start: kernel_frames + 1, that frame itself is never granted
    logic [FRAME_W-1:0]  scan_start;
    logic [WORD_W-1:0]   below_mask;
    logic [WORD_W-1:0]   scan_word;
    logic [WORD_W-1:0]   rsv_mask;
    logic [FRAME_W-1:0]  kf_row;
    logic [FRAME_W-1:0]  disp_pos;
    hit_t                hit;

    assign scan_start = FRAME_W'(kf_reg) + FRAME_W'(1);
    assign below_mask = (WORD_W'(1) << scan_start[WORD_IDX_W-1:0]) - WORD_W'(1);
    assign kf_row     = FRAME_W'(kf_reg[KF_W-1:WORD_IDX_W]);
    assign disp_pos   = (op_reg == OP_FREE) ? (frame_reg - base_reg) : frame_reg;

    // word under test: stored bits, bits below the start, bits past the map
    assign scan_word = rd_data_reg
                     | (first_reg ? below_mask : '0)
                     | ((row_reg == LAST_ROW) ? TAIL_MASK : '0);

    bfa_find_zero u_find_zero
    (
        .word (scan_word),
        .hit  (hit)
    );

    // reservation word: whole rows below the boundary word, partial at it.
    // The map is still all clear here, so the rest of the boundary word is
    // already zero.
    always_comb
    begin
        if (FRAME_W'(cnt_reg) < kf_row)
        begin
            rsv_mask = '1;
        end
        else
        begin
            rsv_mask = (WORD_W'(1) << kf_reg[WORD_IDX_W-1:0]) - WORD_W'(1);
        end
        if (cnt_reg == LAST_ROW)
        begin
            rsv_mask = rsv_mask & ~TAIL_MASK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        first_next     = first_reg;
        reserved_next  = reserved_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        frame_next     = frame_reg;
        done_next      = 1'b0;
        frame_out_next = frame_out_reg;
        status_next    = status_reg;
        is_used_next   = is_used_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = row_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
                cnt_next  = cnt_reg + ROW_W'(1);
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    frame_next = frame;
                    state_next = ST_DISP;
                end
            end

            ST_DISP:
            begin
                pos_next = disp_pos;
                priority case (op_reg)
                    OP_ALLOC:
                    begin
                        if (!reserved_reg)
                        begin
                            reserved_next = 1'b1;
                            cnt_next      = '0;
                            state_next    = (kf_reg != '0) ? ST_RSV : ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_FREE, OP_QUERY:
                    begin
                        if (disp_pos >= NUM_F)
                        begin
                            done_next      = 1'b1;
                            frame_out_next = '0;
                            status_next    = STAT_OUTSIDE;
                            is_used_next   = 1'b0;
                            state_next     = ST_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = disp_pos[WORD_IDX_W +: ROW_W];
                            state_next = (op_reg == OP_FREE) ? ST_FREE : ST_QRY;
                        end
                    end
                    default:
                    begin
                        // unused code: plain zero answer
                        done_next      = 1'b1;
                        frame_out_next = '0;
                        status_next    = STAT_OK;
                        is_used_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                endcase
            end

            ST_RSV:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = rsv_mask;
                cnt_next  = cnt_reg + ROW_W'(1);
                if ((FRAME_W'(cnt_reg) == kf_row) || (cnt_reg == LAST_ROW))
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_start >= NUM_F)
                begin
                    done_next      = 1'b1;
                    frame_out_next = '0;
                    status_next    = STAT_NO_FREE;
                    is_used_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = scan_start[WORD_IDX_W +: ROW_W];
                    row_next   = scan_start[WORD_IDX_W +: ROW_W];
                    first_next = 1'b1;
                    state_next = ST_SCHK;
                end
            end

            ST_SCHK:
            begin
                if (hit.found)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = row_reg;
                    mem_wdata      = rd_data_reg | (WORD_W'(1) << hit.index);
                    done_next      = 1'b1;
                    frame_out_next = FRAME_W'({row_reg, hit.index}) + base_reg;
                    status_next    = STAT_OK;
                    is_used_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (row_reg == LAST_ROW)
                begin
                    done_next      = 1'b1;
                    frame_out_next = '0;
                    status_next    = STAT_NO_FREE;
                    is_used_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = row_reg + ROW_W'(1);
                    row_next   = row_reg + ROW_W'(1);
                    first_next = 1'b0;
                end
            end

            ST_FREE:
            begin
                mem_we         = 1'b1;
                mem_waddr      = pos_reg[WORD_IDX_W +: ROW_W];
                mem_wdata      = rd_data_reg
                               & ~(WORD_W'(1) << pos_reg[WORD_IDX_W-1:0]);
                done_next      = 1'b1;
                frame_out_next = '0;
                status_next    = STAT_OK;
                is_used_next   = 1'b0;
                state_next     = ST_IDLE;
            end

            ST_QRY:
            begin
                done_next      = 1'b1;
                frame_out_next = '0;
                status_next    = STAT_OK;
                is_used_next   = rd_data_reg[pos_reg[WORD_IDX_W-1:0]];
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            cnt_reg      <= '0;
            reserved_reg <= 1'b0;
            done_reg     <= 1'b0;
            kf_reg       <= '0;
            base_reg     <= FRAME_BASE_RST;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            reserved_reg <= reserved_next;
            done_reg     <= done_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_KERNEL_FRAMES: kf_reg   <= wr_data[KF_W-1:0];
                    CFG_FRAME_BASE:    base_reg <= wr_data;
                    default:           ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        first_reg     <= first_next;
        pos_reg       <= pos_next;
        op_reg        <= op_next;
        frame_reg     <= frame_next;
        frame_out_reg <= frame_out_next;
        status_reg    <= status_next;
        is_used_reg   <= is_used_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign frame_out = frame_out_reg;
    assign status    = status_reg;
    assign is_used   = is_used_reg;

endmodule
